/* hdl/fmss_pkg.sv */
// ----------------------------------------------------------------------------
// Frame motion-sharpness score: shared package
// Holds the dimensions, field widths, register indexes, the types that pass
// between the front, the queue and the back, and a small helper function.
// ----------------------------------------------------------------------------
package fmss_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);

   localparam int DIM_W       = 11;
   localparam int LUMA_W      = 8;
   localparam int DIFF_THR_W  = 8;
   localparam int EDGE_THR_W  = 9;
   localparam int GRAD_W      = LUMA_W + 1;
   localparam int SCORE_W     = 30;
   localparam int ENTRY_W     = 2 * LUMA_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = DIM_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIFF_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_THRESHOLD = 2'd3;

   localparam logic [DIM_W-1:0]      RESET_WIDTH    = 11'd640;
   localparam logic [DIM_W-1:0]      RESET_HEIGHT   = 11'd480;
   localparam logic [DIFF_THR_W-1:0] RESET_DIFF_THR = 8'd25;
   localparam logic [EDGE_THR_W-1:0] RESET_EDGE_THR = 9'd25;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [DIM_W-1:0]      width;
      logic [DIM_W-1:0]      height;
      logic [DIFF_THR_W-1:0] diff_thr;
      logic [EDGE_THR_W-1:0] edge_thr;
   } cfg_type;

   // One classified sample on its way from the front to the back.
   typedef struct packed {
      logic              score_en;
      logic              last;
      logic [LUMA_W-1:0] above_cur;
      logic [LUMA_W-1:0] above_prev;
      logic [LUMA_W-1:0] right_cur;
      logic [LUMA_W-1:0] below_cur;
   } item_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
   } queue_status_type;

   function automatic logic [LUMA_W-1:0] abs_diff(input logic [LUMA_W-1:0] a,
                                                   input logic [LUMA_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

/* hdl/frame_motion_sharpness_score.sv */
// ----------------------------------------------------------------------------
// Frame motion-sharpness score: top level
// After the frame's last beat is accepted, the score passes the input stage, the
// queue, the qualify stage and the output register. Throughput: one luma beat
// per cycle unless a full queue stalls the source; the front end reads the line
// memory at two addresses and writes it once in the cycle a beat is accepted.
// Reset clears the position counters, the queue, the running score and the
// output valid; the line memory is not cleared and registers return to defaults.
// ----------------------------------------------------------------------------
module frame_motion_sharpness_score (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [fmss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fmss_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fmss_pkg::LUMA_W-1:0]       req_cur_luma,
   input  logic [fmss_pkg::LUMA_W-1:0]       req_prev_luma,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fmss_pkg::SCORE_W-1:0]      rsp_frame_score
);
   import fmss_pkg::*;

   logic [DIM_W-1:0]      width_ff, width_in;
   logic [DIM_W-1:0]      height_ff, height_in;
   logic [DIFF_THR_W-1:0] diff_thr_ff, diff_thr_in;
   logic [EDGE_THR_W-1:0] edge_thr_ff, edge_thr_in;

   cfg_type          cfg;
   item_type         push_item;
   item_type         pop_item;
   queue_status_type q_status;
   logic             push_valid;
   logic             pop_valid;
   logic             pop_ready;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
      if (v < DIM_W'(2)) begin
         clamp_dim = DIM_W'(2);
      end else if (v > hi) begin
         clamp_dim = hi;
      end else begin
         clamp_dim = v;
      end
   endfunction

   // Dimensions are stored already clamped to the supported range.
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      diff_thr_in = diff_thr_ff;
      edge_thr_in = edge_thr_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = clamp_dim(csr_wdata, DIM_W'(MAX_WIDTH));
            end
            CSR_FRAME_HEIGHT: begin
               height_in = clamp_dim(csr_wdata, DIM_W'(MAX_HEIGHT));
            end
            CSR_DIFF_THRESHOLD: begin
               diff_thr_in = csr_wdata[DIFF_THR_W-1:0];
            end
            CSR_EDGE_THRESHOLD: begin
               edge_thr_in = csr_wdata[EDGE_THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RESET_WIDTH;
         height_ff   <= RESET_HEIGHT;
         diff_thr_ff <= RESET_DIFF_THR;
         edge_thr_ff <= RESET_EDGE_THR;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         diff_thr_ff <= diff_thr_in;
         edge_thr_ff <= edge_thr_in;
      end
   end

   assign cfg.width    = width_ff;
   assign cfg.height   = height_ff;
   assign cfg.diff_thr = diff_thr_ff;
   assign cfg.edge_thr = edge_thr_ff;

   fmss_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cur_luma  (req_cur_luma),
      .req_prev_luma (req_prev_luma),
      .queue_full    (q_status.full),
      .push_valid    (push_valid),
      .push_item     (push_item)
   );

   fmss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .status     (q_status)
   );

   fmss_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .pop_valid       (pop_valid),
      .pop_item        (pop_item),
      .pop_ready       (pop_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_score (rsp_frame_score)
   );

   // A score must never appear straight out of reset.
   a_no_rsp_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("frame score presented straight after reset");

   a_queue_bounded : assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond its depth");

   // The queue moves by at most one entry per cycle.
   a_queue_step : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (q_status.count == $past(q_status.count))
                     || (q_status.count == $past(q_status.count) + QCNT_W'(1))
                     || (q_status.count + QCNT_W'(1) == $past(q_status.count)))
      else $error("queue fill count jumped");

   // A full queue with a stalled input stage must push back on the source.
   a_stall_when_full : assert property (@(posedge clock) disable iff (reset)
      q_status.full && push_valid |-> req_stall)
      else $error("beat accepted while the front stage cannot drain");

endmodule

/* hdl/fmss_front.sv */
// ----------------------------------------------------------------------------
// Frame motion-sharpness score: front end
// Accepts luma beats, tracks the raster position, keeps the previous row in a
// line memory and hands each sample with its neighbours to the queue.
// ----------------------------------------------------------------------------
module fmss_front (
   input  logic                       clock,
   input  logic                       reset,
   input  fmss_pkg::cfg_type          cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [fmss_pkg::LUMA_W-1:0] req_cur_luma,
   input  logic [fmss_pkg::LUMA_W-1:0] req_prev_luma,
   input  logic                       queue_full,
   output logic                       push_valid,
   output fmss_pkg::item_type         push_item
);
   import fmss_pkg::*;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_score_ff;
   logic               s1_last_ff;
   logic [LUMA_W-1:0]  s1_cur_ff;
   logic [ENTRY_W-1:0] above_ff;
   logic [ENTRY_W-1:0] right_ff;
   logic [ENTRY_W-1:0] row_mem_ff [MAX_WIDTH];

   logic               accept;
   logic [DIM_W-1:0]   col_next;
   logic [DIM_W-1:0]   row_next;
   logic               end_row;
   logic               end_frame;
   logic               score_en;
   logic [COL_W-1:0]   right_addr;

   assign req_stall  = s1_valid_ff && queue_full;
   assign accept     = req_valid && !req_stall;

   assign col_next   = DIM_W'(col_ff) + DIM_W'(1);
   assign row_next   = DIM_W'(row_ff) + DIM_W'(1);
   assign end_row    = (col_next >= cfg.width);
   assign end_frame  = end_row && (row_next >= cfg.height);
   assign score_en   = (row_ff != '0) && !end_row;
   assign right_addr = col_ff + COL_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (end_row) begin
            col_in = '0;
            row_in = end_frame ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   // The stage holds its beat while the queue is full.
   assign s1_valid_in = accept || (s1_valid_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Line memory: the reads see the previous row before this beat overwrites
   // its own column.
   always_ff @(posedge clock) begin
      if (accept) begin
         row_mem_ff[col_ff] <= {req_cur_luma, req_prev_luma};
         above_ff           <= row_mem_ff[col_ff];
         right_ff           <= row_mem_ff[right_addr];
         s1_score_ff        <= score_en;
         s1_last_ff         <= end_frame;
         s1_cur_ff          <= req_cur_luma;
      end
   end

   assign push_valid           = s1_valid_ff;
   assign push_item.score_en   = s1_score_ff;
   assign push_item.last       = s1_last_ff;
   assign push_item.above_cur  = above_ff[ENTRY_W-1:LUMA_W];
   assign push_item.above_prev = above_ff[LUMA_W-1:0];
   assign push_item.right_cur  = right_ff[ENTRY_W-1:LUMA_W];
   assign push_item.below_cur  = s1_cur_ff;

endmodule

/* hdl/fmss_queue.sv */
// ----------------------------------------------------------------------------
// Frame motion-sharpness score: decoupling queue
// A short first-in first-out queue of classified samples between the front
// end and the scoring back end.
// ----------------------------------------------------------------------------
module fmss_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  fmss_pkg::item_type         push_item,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output fmss_pkg::item_type         pop_item,
   output fmss_pkg::queue_status_type status
);
   import fmss_pkg::*;

   item_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              full;
   logic              push;
   logic              pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;
   assign pop_item  = entries_ff[rd_ptr_ff];

   assign status.count = count_ff;
   assign status.full  = full;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/fmss_back.sv */
// ----------------------------------------------------------------------------
// Frame motion-sharpness score: back end
// Qualifies each sample on temporal difference and gradient, accumulates the
// qualifying gradients and presents the frame score at the end of a frame.
// ----------------------------------------------------------------------------
module fmss_back (
   input  logic                         clock,
   input  logic                         reset,
   input  fmss_pkg::cfg_type            cfg,
   input  logic                         pop_valid,
   input  fmss_pkg::item_type           pop_item,
   output logic                         pop_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [fmss_pkg::SCORE_W-1:0] rsp_frame_score
);
   import fmss_pkg::*;

   localparam logic [SCORE_W:0] SCORE_MAX = {1'b0, {SCORE_W{1'b1}}};

   logic               a_valid_ff, a_valid_in;
   logic               a_last_ff;
   logic [GRAD_W-1:0]  a_grad_ff;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_score_ff;

   logic [LUMA_W-1:0]  luma_change;
   logic [GRAD_W-1:0]  grad;
   logic               keep;
   logic               a_move;
   logic               pop;
   logic [SCORE_W:0]   sum_wide;
   logic [SCORE_W-1:0] sum_sat;

   assign luma_change = abs_diff(pop_item.above_cur, pop_item.above_prev);
   assign grad = GRAD_W'(abs_diff(pop_item.above_cur, pop_item.right_cur))
               + GRAD_W'(abs_diff(pop_item.above_cur, pop_item.below_cur));
   assign keep = pop_item.score_en && (luma_change > cfg.diff_thr)
              && (grad > cfg.edge_thr);

   // A frame-end beat waits only while the previous score is still unclaimed.
   assign a_move    = a_valid_ff && !(a_last_ff && rsp_valid_ff && rsp_stall);
   assign pop_ready = !a_valid_ff || a_move;
   assign pop       = pop_valid && pop_ready;

   assign a_valid_in = pop || (a_valid_ff && !a_move);

   assign sum_wide = {1'b0, score_ff} + (SCORE_W + 1)'(a_grad_ff);
   assign sum_sat  = (sum_wide > SCORE_MAX) ? SCORE_MAX[SCORE_W-1:0]
                                            : sum_wide[SCORE_W-1:0];

   always_comb begin
      score_in     = score_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (a_move) begin
         if (a_last_ff) begin
            score_in     = '0;
            rsp_valid_in = 1'b1;
         end else begin
            score_in     = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         score_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         score_ff     <= score_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_last_ff <= pop_item.last;
         a_grad_ff <= keep ? grad : '0;
      end
      if (a_move && a_last_ff) begin
         rsp_score_ff <= sum_sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_score = rsp_score_ff;

endmodule

/* tb/frame_motion_sharpness_score_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame motion-sharpness score: testbench
// Streams luma pairs into the scorer under random gaps and result stalls. A
// built-in scoring model tracks the line store, the raster position and the
// running sum, and every frame score the block returns is checked against it.
// ----------------------------------------------------------------------------
module frame_motion_sharpness_score_tb;
   import fmss_pkg::*;

   localparam longint SCORE_LIMIT = (64'd1 << SCORE_W) - 1;
   localparam int     WATCHDOG_NS = 3_000_000;
   localparam int     RANDOM_BEATS = 480;

   typedef struct packed {
      logic [LUMA_W-1:0] cur;
      logic [LUMA_W-1:0] prv;
   } luma_pair_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [LUMA_W-1:0]      req_cur_luma = '0;
   logic [LUMA_W-1:0]      req_prev_luma = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SCORE_W-1:0]     rsp_frame_score;

   // Scoring model state.
   cfg_type           frame_cfg;
   logic [LUMA_W-1:0] line_cur  [MAX_WIDTH];
   logic [LUMA_W-1:0] line_prev [MAX_WIDTH];
   int                col_pos;
   int                row_pos;
   int                store_fill;
   longint            score_acc;

   logic [SCORE_W-1:0] frame_scores_due[$];
   luma_pair_type      pixel_queue[$];
   int                 pixels_queued = 0;
   int                 pixels_accepted = 0;
   int                 mismatches = 0;
   logic               send_idle_on = 1'b0;
   logic               recv_idle_on = 1'b0;
   int                 send_wait = 0;
   int                 recv_hold = 0;

   frame_motion_sharpness_score dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cur_luma    (req_cur_luma),
      .req_prev_luma   (req_prev_luma),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_score (rsp_frame_score)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int clamp_dim(input int value, input int hi);
      return (value < 2) ? 2 : (value > hi) ? hi : value;
   endfunction

   function automatic int luma_dist(input logic [LUMA_W-1:0] a,
                                    input logic [LUMA_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // Advances the model by one accepted beat and queues a score at frame end.
   function automatic void score_pixel(input logic [LUMA_W-1:0] cur,
                                       input logic [LUMA_W-1:0] prv);
      int width_eff;
      int height_eff;
      int x;
      int grad;
      width_eff  = clamp_dim(frame_cfg.width, MAX_WIDTH);
      height_eff = clamp_dim(frame_cfg.height, MAX_HEIGHT);
      x = col_pos;
      if (row_pos > 0 && x + 1 < width_eff && x + 1 < MAX_WIDTH) begin
         if (luma_dist(line_cur[x], line_prev[x]) > int'(frame_cfg.diff_thr)) begin
            grad = luma_dist(line_cur[x], line_cur[x + 1]) + luma_dist(line_cur[x], cur);
            if (grad > int'(frame_cfg.edge_thr)) begin
               score_acc = score_acc + grad;
               if (score_acc > SCORE_LIMIT) score_acc = SCORE_LIMIT;
            end
         end
      end
      line_cur[x]  = cur;
      line_prev[x] = prv;
      if (x + 1 > store_fill) store_fill = x + 1;
      // A narrowed width or height ends the row or frame at once.
      if (x + 1 >= width_eff) begin
         col_pos = 0;
         if (row_pos + 1 >= height_eff) begin
            frame_scores_due.push_back(score_acc[SCORE_W-1:0]);
            score_acc = 0;
            row_pos = 0;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = x + 1;
      end
   endfunction

   function automatic logic [LUMA_W-1:0] pick_luma(input int style);
      case (style)
         0: return LUMA_W'($urandom_range(0, 255));
         1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
         default: return LUMA_W'(96 + $urandom_range(0, 63));
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 40) $display("%0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Holds off until every queued beat is taken and every score has come back,
   // then lets the pipeline empty.
   task automatic wait_idle();
      do @(posedge clock);
      while (pixels_accepted != pixels_queued || frame_scores_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_pair(input logic [LUMA_W-1:0] cur, input logic [LUMA_W-1:0] prv);
      luma_pair_type p;
      p.cur = cur;
      p.prv = prv;
      pixel_queue.push_back(p);
      pixels_queued++;
   endtask

   task automatic queue_pixels(input int count, input int style, input int diff);
      logic [LUMA_W-1:0] cur;
      logic [LUMA_W-1:0] prv;
      int near;
      repeat (count) begin
         cur = pick_luma(style);
         case ($urandom_range(0, 3))
            0: prv = pick_luma(style);
            1: prv = cur;
            default: begin
               // Place the temporal difference just around the threshold.
               near = diff + int'($urandom_range(0, 2)) - 1;
               near = $urandom_range(0, 1) ? int'(cur) + near : int'(cur) - near;
               prv = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : LUMA_W'(near);
            end
         endcase
         queue_pair(cur, prv);
      end
   endtask

   always @(posedge clock) begin : drive_pixels
      luma_pair_type beat;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else if (!req_valid || !req_stall) begin
         if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait--;
         end else if (pixel_queue.size() > 0) begin
            beat = pixel_queue.pop_front();
            req_valid     <= 1'b1;
            req_cur_luma  <= beat.cur;
            req_prev_luma <= beat.prv;
            send_wait = send_idle_on ? int'($urandom_range(0, 4)) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Each score beat is held off for a drawn number of valid cycles.
   always @(posedge clock) begin
      if (reset) begin
         recv_hold = 0;
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         recv_hold = recv_idle_on ? int'($urandom_range(0, 4)) : 0;
         rsp_stall <= (recv_hold > 0);
      end else if (rsp_valid && recv_hold > 0) begin
         recv_hold--;
         rsp_stall <= (recv_hold > 0);
      end
   end

   always @(posedge clock) begin : watch_ports
      logic [SCORE_W-1:0] want;
      if (reset) begin
         frame_cfg.width    = RESET_WIDTH;
         frame_cfg.height   = RESET_HEIGHT;
         frame_cfg.diff_thr = RESET_DIFF_THR;
         frame_cfg.edge_thr = RESET_EDGE_THR;
         col_pos    = 0;
         row_pos    = 0;
         store_fill = 0;
         score_acc  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_scores_due.size() == 0) begin
               report_mismatch($sformatf("frame score %0d with none due", rsp_frame_score));
            end else begin
               want = frame_scores_due.pop_front();
               if (rsp_frame_score !== want)
                  report_mismatch($sformatf("frame score %0d, expected %0d",
                                            rsp_frame_score, want));
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH:    frame_cfg.width    = csr_wdata[DIM_W-1:0];
               CSR_FRAME_HEIGHT:   frame_cfg.height   = csr_wdata[DIM_W-1:0];
               CSR_DIFF_THRESHOLD: frame_cfg.diff_thr = csr_wdata[DIFF_THR_W-1:0];
               CSR_EDGE_THRESHOLD: frame_cfg.edge_thr = csr_wdata[EDGE_THR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            score_pixel(req_cur_luma, req_prev_luma);
            pixels_accepted++;
         end
      end
   end

   initial begin
      #(WATCHDOG_NS);
      $display("frame_motion_sharpness_score: mismatch");
      $finish;
   end

   initial begin
      int plan_w;
      int plan_h;
      int plan_diff;
      int plan_edge;
      int count;
      int area;
      int style;
      int random_items;
      logic last_big;
      random_items = 0;
      last_big = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Two-by-two frames; widths and heights below range run as two.
      write_reg(CSR_FRAME_WIDTH, 11'd1);
      write_reg(CSR_FRAME_HEIGHT, 11'd0);
      write_reg(CSR_DIFF_THRESHOLD, 11'd0);
      write_reg(CSR_EDGE_THRESHOLD, 11'd0);
      queue_pair(8'd255, 8'd0);
      queue_pair(8'd0, 8'd0);
      queue_pair(8'd0, 8'd255);
      queue_pair(8'd0, 8'd0);
      // A flat frame has no temporal difference at all.
      repeat (4) queue_pair(8'd0, 8'd0);
      queue_pair(8'd0, 8'd255);
      queue_pair(8'd255, 8'd255);
      queue_pair(8'd255, 8'd0);
      queue_pair(8'd255, 8'd255);
      wait_idle();
      // Upper data bits fall away: the thresholds become 255 and 510.
      write_reg(CSR_DIFF_THRESHOLD, 11'h7FF);
      write_reg(CSR_EDGE_THRESHOLD, 11'h7FE);
      queue_pair(8'd255, 8'd0);
      queue_pair(8'd0, 8'd255);
      queue_pair(8'd0, 8'd0);
      queue_pair(8'd255, 8'd255);
      wait_idle();
      write_reg(CSR_DIFF_THRESHOLD, 11'd254);
      write_reg(CSR_EDGE_THRESHOLD, 11'd511);
      queue_pair(8'd255, 8'd0);
      queue_pair(8'd0, 8'd255);
      queue_pair(8'd0, 8'd0);
      queue_pair(8'd255, 8'd255);
      wait_idle();
      write_reg(CSR_EDGE_THRESHOLD, 11'd509);
      queue_pair(8'd255, 8'd0);
      queue_pair(8'd0, 8'd255);
      queue_pair(8'd0, 8'd0);
      queue_pair(8'd255, 8'd255);
      wait_idle();

      // A full row and part of the next at the widest width, written out of
      // range so it clamps; the next phase narrows it and ends the frame.
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      plan_diff = $urandom_range(0, 40);
      write_reg(CSR_FRAME_WIDTH, 11'd2047);
      write_reg(CSR_FRAME_HEIGHT, 11'd2);
      write_reg(CSR_DIFF_THRESHOLD, CSR_DATA_W'(plan_diff));
      write_reg(CSR_EDGE_THRESHOLD, CSR_DATA_W'($urandom_range(0, 100)));
      queue_pixels(MAX_WIDTH + MAX_WIDTH / 4, 0, plan_diff);

      while (random_items < RANDOM_BEATS) begin
         wait_idle();
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         style = $urandom_range(0, 2);
         if (!last_big && $urandom_range(0, 7) == 0) begin
            // A brief stretch at a huge dimension; the next phase shrinks it
            // mid-frame, which ends the row or frame at once.
            last_big = 1'b1;
            if ($urandom_range(0, 1)) begin
               case ($urandom_range(0, 2))
                  0: plan_w = 1023;
                  1: plan_w = 1024;
                  default: plan_w = 2047;
               endcase
               plan_h = $urandom_range(2, 3);
            end else begin
               plan_w = $urandom_range(2, 4);
               case ($urandom_range(0, 2))
                  0: plan_h = 1000;
                  1: plan_h = 1024;
                  default: plan_h = 2047;
               endcase
            end
            count = $urandom_range(5, 60);
         end else begin
            last_big = 1'b0;
            plan_w = $urandom_range(0, 10);
            plan_h = $urandom_range(0, 6);
            area = clamp_dim(plan_w, MAX_WIDTH) * clamp_dim(plan_h, MAX_HEIGHT);
            count = $urandom_range(1, 3) * area;
            if ($urandom_range(0, 2) == 0) count += $urandom_range(1, area - 1);
         end
         // Never widen past what the line store holds while rows above are read.
         if (row_pos > 0 && clamp_dim(plan_w, MAX_WIDTH) > store_fill) plan_w = store_fill;
         write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(plan_w));
         write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(plan_h));
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
               0: plan_diff = 0;
               1: plan_diff = 255;
               default: plan_diff = $urandom_range(0, 60);
            endcase
            case ($urandom_range(0, 5))
               0: plan_edge = 0;
               1: plan_edge = 510;
               2: plan_edge = 511;
               default: plan_edge = $urandom_range(0, 255);
            endcase
            write_reg(CSR_DIFF_THRESHOLD, {3'($urandom), 8'(plan_diff)});
            write_reg(CSR_EDGE_THRESHOLD, {2'($urandom), 9'(plan_edge)});
         end
         queue_pixels(count, style, plan_diff);
         random_items += count;
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("frame_motion_sharpness_score: match");
      end else begin
         $display("frame_motion_sharpness_score: mismatch");
      end
      $finish;
   end

endmodule
